### rtl/wpo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wpo_pkg;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SQUARE = 2'd1,
        WAVE_SAW    = 2'd2
    } t_wave;

    // pipeline depth from input transfer to output register, output register included
    localparam int PIPE_STAGES = 12;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [30:0] C1_Q30  = 31'd1686629713;
    localparam logic [30:0] C3_Q30  = 31'd693598668;
    localparam logic [30:0] C5_Q30  = 31'd85569305;
    localparam logic [30:0] C7_Q30  = 31'd5026995;
    localparam logic [30:0] C9_Q30  = 31'd172272;

    localparam logic [15:0] Q15_POS_FULL = 16'h7FFF;
    localparam logic [15:0] Q15_NEG_FULL = 16'h8000;

endpackage

`default_nettype wire

### rtl/wavetable_phase_oscillator.sv
`timescale 1ns / 1ps
`default_nettype none

// Wavetable oscillator. Each input transfer carries an action and a frequency in units of
// 2^-FRACTION_BITS Hz. A tick (action 0) returns the waveform value at the integer part of
// the phase accumulator as a Q1.15 sample, then advances the phase by the frequency clamped
// to 0..SAMPLE_RATE_HZ/2 and wraps it at SAMPLE_RATE_HZ table steps. A trigger (action 1)
// clears the phase and returns nothing. The waveform register selects sine, square or rising
// saw; a write of 3 is ignored. One item is accepted per clock while o_in_ready is high; a
// tick's sample reaches the output register through the twelve-register value pipeline
// (divide-by-rate reciprocal, correction, then a five-term sine polynomial with one
// multiplier per stage). Stages hold while the output is stalled, and input is accepted as
// long as some stage has room. Waveform writes are always accepted.
module wavetable_phase_oscillator
    import wpo_pkg::*;
#(
    parameter int SAMPLE_RATE_HZ = 44100,
    parameter int FRACTION_BITS  = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire logic               i_action,
    input  wire logic signed [23:0] i_frequency,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      logic signed [15:0] o_sample,
    input  wire logic               i_cfg_valid,
    output      logic               o_cfg_ready,
    input  wire logic        [1:0]  i_cfg_data
);

    localparam int IW    = $clog2(SAMPLE_RATE_HZ);
    localparam int PW    = IW + FRACTION_BITS;
    localparam int XW    = (PW > 23) ? PW : 23;
    localparam int SHIFT = 31 + IW;

    localparam logic [PW:0]   MODULUS = (PW + 1)'(64'(SAMPLE_RATE_HZ) << FRACTION_BITS);
    localparam logic [PW-1:0] LIMIT   = PW'(64'(SAMPLE_RATE_HZ >> 1) << FRACTION_BITS);
    localparam logic [IW-1:0] HALF    = IW'(SAMPLE_RATE_HZ / 2);
    localparam logic [63:0]   TWO32   = 64'h1_0000_0000;
    localparam logic [31:0]   QUOT    = 32'(TWO32 / 64'(SAMPLE_RATE_HZ));
    localparam logic [15:0]   REMD    = 16'(TWO32 % 64'(SAMPLE_RATE_HZ));
    localparam logic [31:0]   RECIP   = 32'((64'd1 << SHIFT) / 64'(SAMPLE_RATE_HZ));
    localparam logic [31:0]   RATE32  = 32'(SAMPLE_RATE_HZ);

    function automatic logic [30:0] horner_step(input logic [30:0] c, input logic [30:0] x2,
                                                input logic [30:0] p);
        logic [61:0] prod;
        prod = 62'(x2) * 62'(p);
        return c - prod[60:30];
    endfunction

    // control state
    t_wave                  r_waveform;
    logic [PW-1:0]          r_phase;
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] w_rdy;

    // stage payload
    logic [IW-1:0] r0_idx;
    t_wave         r0_wave;
    logic [31:0]   r1_w, r1_base;
    logic          r1_low;
    t_wave         r1_wave;
    logic [31:0]   r2_q0, r2_w, r2_base;
    logic          r2_low;
    t_wave         r2_wave;
    logic [31:0]   r3_q0, r3_rem, r3_base;
    logic          r3_low;
    t_wave         r3_wave;
    logic [30:0]   r_x     [4:9];
    logic [30:0]   r_x2    [5:8];
    logic [30:0]   r_p     [6:9];
    logic          r_neg   [4:10];
    logic          r_sine  [4:10];
    logic [15:0]   r_fixed [4:10];
    logic [31:0]   r10_s;

    // combinational
    logic              w_in_xfer;
    logic [XW-1:0]     w_freq_mag;
    logic [PW-1:0]     w_step;
    logic [PW:0]       w_sum;
    logic [PW-1:0]     n_phase;
    logic [15:0]       w_mul_k;
    logic [IW+31:0]    w_base_full;
    logic [63:0]       w_recip_prod;
    logic [31:0]       w_qn;
    logic [31:0]       w_q;
    logic [31:0]       w_u;
    logic [30:0]       w_r;
    logic [15:0]       n_fixed;
    logic [61:0]       w_sq;
    logic [61:0]       w_sp;
    logic [47:0]       w_mprod;
    logic [16:0]       w_m;
    logic [15:0]       w_mag;
    logic [15:0]       n_sample;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[PIPE_STAGES-1];
    assign w_in_xfer   = i_in_valid && w_rdy[0];

    always_comb begin
        w_rdy[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || i_out_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // phase advance: clamp, add, single wrap
    always_comb begin
        w_freq_mag = XW'(i_frequency[22:0]);
        if (i_frequency[23]) begin
            w_step = '0;
        end else if (w_freq_mag > XW'(LIMIT)) begin
            w_step = LIMIT;
        end else begin
            w_step = PW'(w_freq_mag);
        end
        w_sum = {1'b0, r_phase} + {1'b0, w_step};
        if (w_sum >= MODULUS) begin
            n_phase = PW'(w_sum - MODULUS);
        end else begin
            n_phase = PW'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform <= WAVE_SINE;
            r_phase    <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_data <= 2'(WAVE_SAW)) begin
                r_waveform <= t_wave'(i_cfg_data);
            end
            if (w_in_xfer) begin
                r_phase <= i_action ? '0 : n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= w_in_xfer && !i_action;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // u = floor(idx * 2^32 / N) = idx*QUOT + floor(idx*REMD / N); saw shares the divider
    always_comb begin
        w_mul_k      = (r0_wave == WAVE_SAW) ? 16'hFFFF : REMD;
        w_base_full  = r0_idx * QUOT;
        w_recip_prod = 64'(r1_w) * 64'(RECIP);
        w_qn         = r2_q0 * RATE32;
        w_q          = r3_q0 + ((r3_rem >= RATE32) ? 32'd1 : 32'd0);
        w_u          = r3_base + w_q;
        w_r          = {1'b0, w_u[29:0]};
        unique case (r3_wave)
            WAVE_SQUARE: n_fixed = r3_low ? Q15_POS_FULL : Q15_NEG_FULL;
            WAVE_SAW:    n_fixed = w_q[15:0] + Q15_NEG_FULL;
            default:     n_fixed = '0;
        endcase
        w_sq    = 62'(r_x[4]) * 62'(r_x[4]);
        w_sp    = 62'(r_x[9]) * 62'(r_p[9]);
        w_mprod = 48'(r10_s) * 48'(Q15_POS_FULL) + 48'(ONE_Q30 >> 1);
        w_m     = w_mprod[46:30];
        w_mag   = (w_m > 17'(Q15_POS_FULL)) ? Q15_POS_FULL : w_m[15:0];
        if (!r_sine[10]) begin
            n_sample = r_fixed[10];
        end else if (r_neg[10]) begin
            n_sample = -w_mag;
        end else begin
            n_sample = w_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r0_idx  <= r_phase[PW-1:FRACTION_BITS];
            r0_wave <= r_waveform;
        end
        if (w_rdy[1]) begin
            r1_w    <= 32'(r0_idx) * 32'(w_mul_k);
            r1_base <= w_base_full[31:0];
            r1_low  <= r0_idx < HALF;
            r1_wave <= r0_wave;
        end
        if (w_rdy[2]) begin
            r2_q0   <= 32'(w_recip_prod >> SHIFT);
            r2_w    <= r1_w;
            r2_base <= r1_base;
            r2_low  <= r1_low;
            r2_wave <= r1_wave;
        end
        if (w_rdy[3]) begin
            r3_q0   <= r2_q0;
            r3_rem  <= r2_w - w_qn;
            r3_base <= r2_base;
            r3_low  <= r2_low;
            r3_wave <= r2_wave;
        end
        if (w_rdy[4]) begin
            // fold odd quadrants back onto the first
            r_x[4]     <= w_u[30] ? (ONE_Q30 - w_r) : w_r;
            r_neg[4]   <= w_u[31];
            r_sine[4]  <= r3_wave == WAVE_SINE;
            r_fixed[4] <= n_fixed;
        end
        if (w_rdy[5]) begin
            r_x[5]  <= r_x[4];
            r_x2[5] <= w_sq[60:30];
        end
        if (w_rdy[6]) begin
            r_x[6]  <= r_x[5];
            r_x2[6] <= r_x2[5];
            r_p[6]  <= horner_step(C7_Q30, r_x2[5], C9_Q30);
        end
        if (w_rdy[7]) begin
            r_x[7]  <= r_x[6];
            r_x2[7] <= r_x2[6];
            r_p[7]  <= horner_step(C5_Q30, r_x2[6], r_p[6]);
        end
        if (w_rdy[8]) begin
            r_x[8]  <= r_x[7];
            r_x2[8] <= r_x2[7];
            r_p[8]  <= horner_step(C3_Q30, r_x2[7], r_p[7]);
        end
        if (w_rdy[9]) begin
            r_x[9] <= r_x[8];
            r_p[9] <= horner_step(C1_Q30, r_x2[8], r_p[8]);
        end
        if (w_rdy[10]) begin
            r10_s <= w_sp[61:30];
        end
        for (int k = 5; k <= 10; k++) begin
            if (w_rdy[k]) begin
                r_neg[k]   <= r_neg[k-1];
                r_sine[k]  <= r_sine[k-1];
                r_fixed[k] <= r_fixed[k-1];
            end
        end
        if (w_rdy[11]) begin
            o_sample <= n_sample;
        end
    end

endmodule

`default_nettype wire

### rtl/wpo_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wpo_checker
    import wpo_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               i_action,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [15:0] o_sample
);

    localparam int CW = $clog2(PIPE_STAGES + 1);

    logic [CW-1:0] r_pending;
    logic          w_tick_xfer;
    logic          w_out_xfer;

    assign w_tick_xfer = i_in_valid && o_in_ready && !i_action;
    assign w_out_xfer  = o_out_valid && i_out_ready;

    // ticks taken in minus samples delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_tick_xfer && !w_out_xfer) begin
            r_pending <= r_pending + 1'b1;
        end else if (w_out_xfer && !w_tick_xfer) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != '0)
        else $error("sample shown with no tick outstanding");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= CW'(PIPE_STAGES))
        else $error("more ticks in flight than pipeline stages");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_sample)))
        else $error("stalled output transfer changed");

endmodule

bind wavetable_phase_oscillator wpo_checker u_wpo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_sample    (o_sample)
);

`default_nettype wire

### verif/tb_wavetable_phase_oscillator.sv
`timescale 1ns / 1ps

module tb_wavetable_phase_oscillator;
    import wpo_pkg::*;

    localparam int RATE_HZ   = 44100;
    localparam int FRAC_BITS = 8;
    localparam int unsigned PHASE_MOD  = RATE_HZ << FRAC_BITS;
    localparam int unsigned FREQ_LIMIT = (RATE_HZ >> 1) << FRAC_BITS;
    localparam int QUARTER_STEP = (RATE_HZ / 4) << FRAC_BITS;

    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_TRIGGER = 1'b1;
    localparam logic [1:0] WAVE_RESERVED = 2'd3;

    localparam int DRAIN_CYCLES = PIPE_STAGES + 8;
    localparam int MAX_REPORTS  = 10;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_action = ACT_TICK;
    logic signed [23:0] in_frequency = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [1:0]         cfg_data = '0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [15:0] o_sample;
    logic               o_cfg_ready;

    // predictor state
    t_wave              wave_sel = WAVE_SINE;
    int unsigned        osc_phase = 0;
    logic signed [15:0] sample_q[$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int mismatches = 0;

    wavetable_phase_oscillator #(
        .SAMPLE_RATE_HZ(RATE_HZ),
        .FRACTION_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (in_action),
        .i_frequency(in_frequency),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_sample   (o_sample),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic signed [15:0] table_value(input t_wave wave, input int unsigned idx);
        logic [63:0] u, r, x, x2, p, s, m, v;
        logic [1:0]  quad;
        if (idx >= RATE_HZ)
            idx = RATE_HZ - 1;
        if (wave == WAVE_SQUARE)
            return (idx < RATE_HZ / 2) ? Q15_POS_FULL : Q15_NEG_FULL;
        if (wave == WAVE_SAW) begin
            v = (64'(idx) * 64'd65535) / 64'(RATE_HZ);
            return 16'(int'(v) - 32768);
        end
        // angle in 2^-32 turns, folded into the first quadrant
        u = (64'(idx) << 32) / 64'(RATE_HZ);
        quad = u[31:30];
        r = {34'd0, u[29:0]};
        x = quad[0] ? 64'(ONE_Q30) - r : r;
        x2 = (x * x) >> 30;
        p = 64'(C9_Q30);
        p = 64'(C7_Q30) - ((x2 * p) >> 30);
        p = 64'(C5_Q30) - ((x2 * p) >> 30);
        p = 64'(C3_Q30) - ((x2 * p) >> 30);
        p = 64'(C1_Q30) - ((x2 * p) >> 30);
        s = (x * p) >> 30;
        m = (s * 64'd32767 + (64'(ONE_Q30) >> 1)) >> 30;
        if (m > 64'd32767)
            m = 64'd32767;
        return quad[1] ? -m[15:0] : m[15:0];
    endfunction

    function automatic logic signed [15:0] advance_oscillator(input logic [23:0] freq);
        int unsigned step;
        logic signed [15:0] value;
        if (freq[23])
            step = 0;
        else if (freq > FREQ_LIMIT)
            step = FREQ_LIMIT;
        else
            step = 32'(freq);
        value = table_value(wave_sel, osc_phase >> FRAC_BITS);
        osc_phase = osc_phase + step;
        if (osc_phase >= PHASE_MOD)
            osc_phase = osc_phase - PHASE_MOD;
        return value;
    endfunction

    always @(posedge i_clk)
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);

    // outputs are stable mid-cycle; a transfer there completes at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (sample_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected sample %0d", o_sample);
            end else begin
                if (o_sample !== sample_q[0]) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("sample mismatch: expected %0d, got %0d",
                                 sample_q[0], o_sample);
                end
                void'(sample_q.pop_front());
            end
        end
    end

    task automatic send_item(input logic act, input logic [23:0] freq);
        logic took;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        in_action    <= act;
        in_frequency <= freq;
        do begin
            @(negedge i_clk);
            took = o_in_ready;
            if (took) begin
                if (act == ACT_TRIGGER)
                    osc_phase = 0;
                else
                    sample_q.push_back(advance_oscillator(freq));
            end
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic tick(input logic [23:0] freq);
        send_item(ACT_TICK, freq);
    endtask

    task automatic trigger();
        send_item(ACT_TRIGGER, 24'($urandom()));
    endtask

    // triggers leave nothing in the queue, so also let the pipeline run dry
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sample_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_waveform(input logic [1:0] data);
        logic took;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= data;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            if (took && data != WAVE_RESERVED)
                wave_sel = t_wave'(data);
            @(posedge i_clk);
        end while (!took);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] rand_frequency();
        case ($urandom_range(0, 5))
            0: return 24'($urandom());
            1: return 24'($urandom_range(0, FREQ_LIMIT));
            2: return 24'($urandom_range(FREQ_LIMIT - 8, FREQ_LIMIT + 8));
            3: return {1'b1, 23'($urandom())};
            4: return 24'($urandom_range(0, 4096));
            default: return 24'($urandom_range(FREQ_LIMIT + 1, 24'h7F_FFFF));
        endcase
    endfunction

    task automatic test_clamping();
        tick(24'd0);
        tick(24'h7F_FFFF);
        tick(24'h80_0000);
        tick(24'hFF_FFFF);
        tick(24'(FREQ_LIMIT + 1));
        tick(24'd256);
        tick(24'(FREQ_LIMIT));
    endtask

    // quarter-period steps land on the sine quadrant edges; then reach the last index
    task automatic test_table_edges();
        trigger();
        repeat (4) tick(24'(QUARTER_STEP));
        tick(24'(FREQ_LIMIT));
        tick(24'(FREQ_LIMIT - 256));
        tick(24'd0);
    endtask

    task automatic test_trigger();
        tick(24'd12345);
        send_item(ACT_TRIGGER, 24'h7F_FFFF);
        tick(24'd0);
    endtask

    task automatic test_waveforms();
        write_waveform(WAVE_SQUARE);
        tick(24'(FREQ_LIMIT - 128));
        tick(24'(FREQ_LIMIT - 128));
        write_waveform(WAVE_SAW);
        tick(24'(FREQ_LIMIT - 128));
        tick(24'(FREQ_LIMIT - 128));
        // reserved code must leave the saw selected
        write_waveform(WAVE_RESERVED);
        tick(24'd777);
        write_waveform(WAVE_SINE);
    endtask

    task automatic test_random(input int count, input bit pause_midway);
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2)
                wait_drained();
            if ($urandom_range(0, 99) < 8)
                trigger();
            else
                tick(rand_frequency());
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        tx_idle_pct  = 14;
        rx_stall_pct = 80;
        test_clamping();
        test_table_edges();
        test_trigger();
        test_waveforms();

        write_waveform(2'($urandom_range(0, 3)));
        test_random(160, 1'b0);
        write_waveform(2'($urandom_range(0, 3)));
        test_random(160, 1'b0);

        tx_idle_pct  = 80;
        rx_stall_pct = 14;
        write_waveform(WAVE_SAW);
        test_random(160, 1'b1);
        write_waveform(2'($urandom_range(0, 3)));
        test_random(160, 1'b0);

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_waveform(WAVE_SQUARE);
        test_random(155, 1'b0);
        write_waveform(WAVE_SINE);
        test_random(155, 1'b0);

        wait_drained();
        if (mismatches == 0 && sample_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
rtl/wpo_pkg.sv
rtl/wavetable_phase_oscillator.sv
rtl/wpo_checker.sv
verif/tb_wavetable_phase_oscillator.sv
